// ===== hdl/tsc_pkg.sv =====
// ---------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the terrain stencil
// Window item layout, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int ENTRY_W  = 25;
    localparam int MISS_IDX = 24;

    localparam logic [ENTRY_W-1:0] MISS_ENTRY = 25'h1000000;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_SPACING = 2'd2;

    localparam logic [10:0] WIDTH_RST   = 11'd256;
    localparam logic [10:0] HEIGHT_RST  = 11'd256;
    localparam logic [23:0] SPACING_RST = 24'd256;

    typedef logic [ENTRY_W-1:0] entry_t;

    // one plus-shaped window with the position of its centre cell
    typedef struct packed {
        entry_t     we;
        entry_t     ce;
        entry_t     ee;
        entry_t     ne;
        entry_t     se;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } win_t;

endpackage

`default_nettype wire

// ===== hdl/terrain_slope_curvature_stencil.sv =====
// ---------------------------------------------------------------------------
// terrain_slope_curvature_stencil: slope and curvature of a height raster
// Forms a plus-shaped window one row behind the input and reports the
// negated normal's z and the negated Laplacian over L squared for every cell.
// ---------------------------------------------------------------------------
//
// channel   direction  transfer when          carries
// s_*       in         s_tvalid & s_tready    one height sample
// m_*       out        m_tvalid & m_tready    one cell result
// cfg_*     in         cfg_valid & cfg_ready  one register write
//
// The intake takes a sample and pushes its window before it takes the next, while the window queue has room.
// A cell with data passes from pop through mirroring, squaring, summing and a saturation
// check, a 16-bit slope search (states KX, P0, P1 and CMP for each bit) and a 32-step divider
// (the search ends early when the ground is level, the divider is skipped when the curvature saturates);
// a cell with no data goes from mirroring straight to the output register.
// Reset clears counters, window and handshakes; row stores need no clear.
// A stalled output holds its result while the intake keeps filling the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module terrain_slope_curvature_stencil #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // [23:0] height_sample
    input  wire logic          s_tuser,   // [0] missing
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,   // [15:0] slope, [47:16] curvature,
                                          // [57:48] column, [67:58] row
    output logic               m_tuser,   // [0] no_data
    output logic               m_tlast,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [23:0]   cfg_data
);

    logic [10:0]   width_reg;
    logic [10:0]   height_reg;
    logic [23:0]   spacing_reg;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    tsc_pkg::win_t q_in;
    tsc_pkg::win_t q_out;

    // register writes are always accepted: cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= tsc_pkg::WIDTH_RST;
            height_reg  <= tsc_pkg::HEIGHT_RST;
            spacing_reg <= tsc_pkg::SPACING_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tsc_pkg::CFG_WIDTH:   width_reg   <= cfg_data[10:0];
                tsc_pkg::CFG_HEIGHT:  height_reg  <= cfg_data[10:0];
                tsc_pkg::CFG_SPACING: spacing_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // intake: counters, row stores, window forming
    tsc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .width_in_use  (width_reg),
        .height_in_use (height_reg),
        .push          (q_push),
        .push_item     (q_in),
        .full          (q_full)
    );

    // hold up to two windows between intake and arithmetic
    tsc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    // arithmetic and output register
    tsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop_item (q_out),
        .pop      (q_pop),
        .spacing  (spacing_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/tsc_fifo.sv =====
// ---------------------------------------------------------------------------
// tsc_fifo: two-entry window queue
// Decouples the window former from the arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none

module tsc_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tsc_pkg::win_t push_item,
    output logic               full,
    input  wire logic          pop,
    output tsc_pkg::win_t      pop_item,
    output logic               empty
);

    tsc_pkg::win_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tsc_front.sv =====
// ---------------------------------------------------------------------------
// tsc_front: sample intake and window former
// Keeps the row stores and counters and queues one window per cell.
// ---------------------------------------------------------------------------
`default_nettype none

module tsc_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,
    input  wire logic          s_tuser,
    input  wire logic [10:0]   width_in_use,
    input  wire logic [10:0]   height_in_use,
    output logic               push,
    output tsc_pkg::win_t      push_item,
    input  wire logic          full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    localparam logic F_IDLE = 1'b0;
    localparam logic F_PUSH = 1'b1;

    logic                  state_reg;
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    tsc_pkg::entry_t       entry_reg;
    tsc_pkg::entry_t       prev_ce_reg;
    tsc_pkg::entry_t       rd_c_reg;
    tsc_pkg::entry_t       rd_e_reg;
    tsc_pkg::entry_t       rd_n_reg;

    tsc_pkg::entry_t       cur_mem  [MAX_WIDTH];
    tsc_pkg::entry_t       prev_mem [MAX_WIDTH];

    logic [31:0]   w_wide;
    logic [31:0]   h_wide;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] col_p1;
    logic          row_end;
    logic          pad_row;
    logic          has_result;
    logic          step;
    logic [RW-1:0] row_m1;
    logic [CW+9:0] col_ext;
    logic [RW+9:0] row_ext;
    logic          accept;

    // clamp the frame size into 1..MAX
    always_comb
    begin
        w_wide = {21'b0, width_in_use};
        h_wide = {21'b0, height_in_use};
        if (w_wide == 32'd0)
        begin
            w_eff = WW'(1);
        end
        else if (w_wide > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_wide[WW-1:0];
        end
        if (h_wide == 32'd0)
        begin
            h_eff = RW'(1);
        end
        else if (h_wide > 32'(MAX_HEIGHT))
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_wide[RW-1:0];
        end
    end

    assign col_p1     = CW'(col_reg + 1'b1);
    assign row_end    = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign pad_row    = 32'(row_reg) >= 32'(h_eff);
    assign has_result = (row_reg != '0);
    assign s_tready   = (state_reg == F_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign step       = (state_reg == F_PUSH) && (!has_result || !full);
    assign push       = (state_reg == F_PUSH) && has_result && !full;
    assign row_m1     = row_reg - 1'b1;
    assign col_ext    = {10'b0, col_reg};
    assign row_ext    = {10'b0, row_m1};

    always_comb
    begin
        push_item.we   = (col_reg != '0) ? prev_ce_reg : tsc_pkg::MISS_ENTRY;
        push_item.ce   = rd_c_reg;
        push_item.ee   = row_end ? tsc_pkg::MISS_ENTRY : rd_e_reg;
        push_item.ne   = (32'(row_reg) >= 32'd2) ? rd_n_reg : tsc_pkg::MISS_ENTRY;
        push_item.se   = entry_reg;
        push_item.col  = col_ext[9:0];
        push_item.row  = row_ext[9:0];
        push_item.last = pad_row && row_end;
    end

    // row stores: read every cycle at the current column, write on step
    always_ff @(posedge clk)
    begin
        rd_c_reg <= cur_mem[col_reg];
        rd_e_reg <= cur_mem[col_p1];
        rd_n_reg <= prev_mem[col_reg];
        if (step)
        begin
            cur_mem[col_reg]  <= entry_reg;
            prev_mem[col_reg] <= rd_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= (s_tuser || pad_row) ? tsc_pkg::MISS_ENTRY : {1'b0, s_tdata};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            prev_ce_reg <= tsc_pkg::MISS_ENTRY;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (step)
                    begin
                        state_reg   <= F_IDLE;
                        prev_ce_reg <= rd_c_reg;
                        if (row_end)
                        begin
                            col_reg <= '0;
                            row_reg <= pad_row ? '0 : RW'(row_reg + 1'b1);
                        end
                        else
                        begin
                            col_reg <= col_p1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tsc_back.sv =====
// ---------------------------------------------------------------------------
// tsc_back: slope and curvature unit
// Mirrors missing neighbours, searches the slope bit by bit and divides.
// ---------------------------------------------------------------------------
`default_nettype none

module tsc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          empty,
    input  wire tsc_pkg::win_t pop_item,
    output logic               pop,
    input  wire logic [23:0]   spacing,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_MIR  = 4'd1;
    localparam logic [3:0] B_SQ   = 4'd2;
    localparam logic [3:0] B_SUM  = 4'd3;
    localparam logic [3:0] B_SAT  = 4'd4;
    localparam logic [3:0] B_KX   = 4'd5;
    localparam logic [3:0] B_P0   = 4'd6;
    localparam logic [3:0] B_P1   = 4'd7;
    localparam logic [3:0] B_CMP  = 4'd8;
    localparam logic [3:0] B_DIVI = 4'd9;
    localparam logic [3:0] B_DIV  = 4'd10;
    localparam logic [3:0] B_OUT  = 4'd11;

    logic [3:0]         state_reg;
    tsc_pkg::win_t      it_reg;
    logic               nd_reg;
    logic signed [26:0] dx_reg;
    logic signed [26:0] dy_reg;
    logic signed [27:0] lap_reg;
    logic [47:0]        l2_reg;
    logic [52:0]        dxsq_reg;
    logic [52:0]        dysq_reg;
    logic [50:0]        mag_reg;
    logic [53:0]        s_reg;
    logic [52:0]        n_reg;
    logic [48:0]        d_reg;
    logic               sat_reg;
    logic [15:0]        m_reg;
    logic [3:0]         bit_reg;
    logic [31:0]        p_reg;
    logic [85:0]        acc_reg;
    logic [79:0]        dsh_reg;
    logic [31:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;
    logic               out_user_reg;
    logic               out_last_reg;

    logic signed [25:0] c_v, w_v, e_v, n_v, s_v;
    logic signed [25:0] wm, em, nm, sm;
    logic signed [27:0] lap_c;
    logic [23:0]        l_eff;
    logic signed [53:0] pdx, pdy;
    logic [27:0]        lap_abs;
    logic [15:0]        cand;
    logic [16:0]        x17;
    logic [58:0]        part;
    logic [31:0]        curv;
    logic [15:0]        slope;
    logic               out_free;

    function automatic logic signed [25:0] mir(input logic signed [25:0] c,
                                               input logic signed [25:0] a,
                                               input logic signed [25:0] b,
                                               input logic ma,
                                               input logic mb);
        logic signed [25:0] r;
        if (ma && mb)
        begin
            r = c;
        end
        else if (ma)
        begin
            r = (c <<< 1) - b;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

    always_comb
    begin
        c_v = {{2{it_reg.ce[23]}}, it_reg.ce[23:0]};
        w_v = {{2{it_reg.we[23]}}, it_reg.we[23:0]};
        e_v = {{2{it_reg.ee[23]}}, it_reg.ee[23:0]};
        n_v = {{2{it_reg.ne[23]}}, it_reg.ne[23:0]};
        s_v = {{2{it_reg.se[23]}}, it_reg.se[23:0]};
        wm = mir(c_v, w_v, e_v, it_reg.we[tsc_pkg::MISS_IDX], it_reg.ee[tsc_pkg::MISS_IDX]);
        em = mir(c_v, e_v, w_v, it_reg.ee[tsc_pkg::MISS_IDX], it_reg.we[tsc_pkg::MISS_IDX]);
        nm = mir(c_v, n_v, s_v, it_reg.ne[tsc_pkg::MISS_IDX], it_reg.se[tsc_pkg::MISS_IDX]);
        sm = mir(c_v, s_v, n_v, it_reg.se[tsc_pkg::MISS_IDX], it_reg.ne[tsc_pkg::MISS_IDX]);
        lap_c = {{2{wm[25]}}, wm} + {{2{em[25]}}, em} + {{2{nm[25]}}, nm}
              + {{2{sm[25]}}, sm} - ({{2{c_v[25]}}, c_v} <<< 2);
    end

    assign l_eff   = (spacing == 24'd0) ? 24'd1 : spacing;
    assign pdx     = dx_reg * dx_reg;
    assign pdy     = dy_reg * dy_reg;
    assign lap_abs = lap_reg[27] ? 28'(-lap_reg) : 28'(lap_reg);
    assign cand    = m_reg | (16'd1 << bit_reg);
    assign x17     = {cand, 1'b0} - 17'd1;
    assign part    = (state_reg == B_P0) ? 59'(p_reg * s_reg[26:0])
                                         : 59'(p_reg * s_reg[53:27]);
    assign out_free = !out_valid_reg || m_tready;
    assign pop     = (state_reg == B_IDLE) && !empty;

    // saturate the rounded quotient and apply the sign
    always_comb
    begin
        if (nd_reg)
        begin
            curv = 32'd0;
        end
        else if (!lap_reg[27] && lap_reg != '0)
        begin
            curv = (sat_reg || q_reg > 32'h80000000) ? 32'h80000000 : 32'(-q_reg);
        end
        else
        begin
            curv = (sat_reg || q_reg[31]) ? 32'h7FFFFFFF : q_reg;
        end
        slope = nd_reg ? 16'd0 : 16'(-m_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    it_reg <= pop_item;
                end
            end
            B_MIR:
            begin
                dx_reg  <= {em[25], em} - {wm[25], wm};
                dy_reg  <= {nm[25], nm} - {sm[25], sm};
                lap_reg <= lap_c;
                l2_reg  <= l_eff * l_eff;
            end
            B_SQ:
            begin
                dxsq_reg <= pdx[52:0];
                dysq_reg <= pdy[52:0];
                mag_reg  <= {lap_abs[26:0], 24'b0};
            end
            B_SUM:
            begin
                s_reg <= 54'(dxsq_reg) + 54'(dysq_reg) + {4'b0, l2_reg, 2'b0};
                n_reg <= {1'b0, mag_reg, 1'b0} + 53'(l2_reg);
                d_reg <= {l2_reg, 1'b0};
            end
            B_SAT:
            begin
                sat_reg <= {28'b0, n_reg} >= {d_reg, 32'b0};
            end
            B_KX:
            begin
                p_reg <= x17[15:0] * x17[15:0];
            end
            B_P0:
            begin
                acc_reg <= 86'(part);
            end
            B_P1:
            begin
                acc_reg <= acc_reg + {part, 27'b0};
            end
            B_DIVI:
            begin
                dsh_reg <= {d_reg, 31'b0};
            end
            B_DIV:
            begin
                if ({27'b0, n_reg} >= dsh_reg)
                begin
                    n_reg <= n_reg - dsh_reg[52:0];
                end
                dsh_reg <= dsh_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_OUT && out_free)
        begin
            out_data_reg <= {4'b0, it_reg.row, it_reg.col, curv, slope};
            out_user_reg <= nd_reg;
            out_last_reg <= it_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            nd_reg        <= 1'b0;
            m_reg         <= '0;
            bit_reg       <= '0;
            q_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new result, or drop the one just taken
            if (state_reg == B_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        nd_reg    <= pop_item.ce[tsc_pkg::MISS_IDX];
                        state_reg <= B_MIR;
                    end
                end
                B_MIR:
                begin
                    state_reg <= nd_reg ? B_OUT : B_SQ;
                end
                B_SQ:
                begin
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    m_reg     <= '0;
                    bit_reg   <= 4'd15;
                    state_reg <= B_SAT;
                end
                B_SAT:
                begin
                    state_reg <= B_KX;
                end
                B_KX:
                begin
                    // slope is capped at one: no bit may follow the top one
                    state_reg <= m_reg[15] ? B_DIVI : B_P0;
                end
                B_P0:
                begin
                    state_reg <= B_P1;
                end
                B_P1:
                begin
                    state_reg <= B_CMP;
                end
                B_CMP:
                begin
                    if (acc_reg <= {4'b0, l2_reg, 34'b0})
                    begin
                        m_reg <= cand;
                    end
                    if (bit_reg == 4'd0)
                    begin
                        state_reg <= B_DIVI;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= B_KX;
                    end
                end
                B_DIVI:
                begin
                    q_reg     <= '0;
                    cnt_reg   <= 5'd31;
                    state_reg <= sat_reg ? B_OUT : B_DIV;
                end
                B_DIV:
                begin
                    if ({27'b0, n_reg} >= dsh_reg)
                    begin
                        q_reg[cnt_reg] <= 1'b1;
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/tsc_check.sv =====
// ---------------------------------------------------------------------------
// tsc_check: port checks for the terrain stencil
// Watches the result channel over time.
// ---------------------------------------------------------------------------
`default_nettype none

module tsc_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a cell with no data carries zero slope and curvature
    a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[47:0] == 48'd0)
        else $error("no-data result with nonzero values");

    // slope is never positive
    a_slope: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15] || m_tdata[15:0] == 16'd0)
        else $error("positive slope");

endmodule

bind terrain_slope_curvature_stencil tsc_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/tb_terrain_slope_curvature_stencil.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_terrain_slope_curvature_stencil: self-checking bench of the slope stencil
// Streams height frames (each closed by a padding row) through the block,
// predicts every cell result with a bit-true model of the window arithmetic
// and compares each output transfer field by field, in order.
// ---------------------------------------------------------------------------
module tb_terrain_slope_curvature_stencil;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // index with no register behind it

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int SETTLE       = 300;   // idle wait after draining, before a register write
    localparam int WATCHDOG     = 5000;
    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_TAIL   = 100;

    typedef struct packed {
        logic [15:0] slope;
        logic [31:0] curv;
        logic        nd;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
    } cell_t;

    typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

    // one line of the directed stimulus; typed result only where obvious
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [23:0] value;
        bit          miss;
        bit          drain;
        bit          known;
        cell_t       typed;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    terrain_slope_curvature_stencil dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: registers, both row stores, held centre, counters
    // ------------------------------------------------------------------
    logic [10:0]      p_width   = tsc_pkg::WIDTH_RST;
    logic [10:0]      p_height  = tsc_pkg::HEIGHT_RST;
    logic [23:0]      p_spacing = tsc_pkg::SPACING_RST;
    tsc_pkg::entry_t  prev_row [MAX_W];
    tsc_pkg::entry_t  cur_row  [MAX_W];
    tsc_pkg::entry_t  last_centre = tsc_pkg::MISS_ENTRY;
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;

    cell_t    pending_cells [$];
    dir_row_t dir_rows [$];
    int       errors = 0;
    bit       quiet = 1'b0;       // no idling on either side in the tail
    int       rand_items = 0;
    int       stuck = 0;
    int       ready_hold = 0;

    function automatic longint hval(tsc_pkg::entry_t e);
        return longint'($signed(e[23:0]));
    endfunction

    // fill in a missing neighbor by reflecting the other side through the centre
    function automatic void mirror_pair(input longint c, input bit ma, input bit mb,
                                        inout longint a, inout longint b);
        if (ma && mb)
        begin
            a = c;
            b = c;
        end
        else if (ma)
            a = 2 * c - b;
        else if (mb)
            b = 2 * c - a;
    endfunction

    // (2m-1)^2 * s <= 2^34 * l2, i.e. 65536*L/sqrt(s) rounds to at least m
    function automatic bit slope_reaches(longint unsigned m, longint unsigned s,
                                         longint unsigned l2);
        logic [127:0] k, lhs, rhs;
        k   = 128'(2 * m - 1);
        lhs = k * k * 128'(s);
        rhs = 128'(l2) << 34;
        return lhs <= rhs;
    endfunction

    function automatic void cell_math(input tsc_pkg::entry_t we, input tsc_pkg::entry_t ce,
                                      input tsc_pkg::entry_t ee, input tsc_pkg::entry_t ne,
                                      input tsc_pkg::entry_t se,
                                      output logic [15:0] sl, output logic [31:0] cv);
        longint c, w, e, n, s, dx, dy, lap;
        longint unsigned l, l2, sum, mag, q, lo, hi, mid;
        c = hval(ce);
        w = hval(we);
        e = hval(ee);
        n = hval(ne);
        s = hval(se);
        l = (p_spacing == 0) ? 1 : p_spacing;
        l2 = l * l;
        mirror_pair(c, we[tsc_pkg::MISS_IDX], ee[tsc_pkg::MISS_IDX], w, e);
        mirror_pair(c, ne[tsc_pkg::MISS_IDX], se[tsc_pkg::MISS_IDX], n, s);
        dx = e - w;
        dy = n - s;
        sum = longint'(dx * dx) + longint'(dy * dy) + 4 * l2;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (slope_reaches(mid, sum, l2))
                lo = mid;
            else
                hi = mid - 1;
        end
        sl = 16'(64'd0 - lo);
        lap = w + e + n + s - 4 * c;
        mag = longint'(lap < 0 ? -lap : lap) << 24;
        q = (2 * mag + l2) / (2 * l2);
        if (lap > 0)
            cv = (q > 64'd2147483648) ? 32'h80000000 : 32'(-longint'(q));
        else
            cv = (q > 64'd2147483647) ? 32'h7FFFFFFF : 32'(q);
    endfunction

    // advance the window by one sample; returns 1 when a cell result falls out
    function automatic bit advance_window(input logic [23:0] hgt, input bit miss,
                                          output cell_t res);
        int unsigned     wv, hv, r, c;
        tsc_pkg::entry_t entry, we, ce, ee, ne;
        bit              row_end, has;
        wv = (p_width == 0) ? 1 : ((p_width > MAX_W) ? MAX_W : p_width);
        hv = (p_height == 0) ? 1 : ((p_height > MAX_H) ? MAX_H : p_height);
        r = row_cnt;
        c = col_cnt;
        entry = (miss || r >= hv) ? tsc_pkg::MISS_ENTRY : {1'b0, hgt};
        ce = cur_row[c];
        ee = (c + 1 < wv) ? cur_row[c + 1] : tsc_pkg::MISS_ENTRY;
        we = (c > 0) ? last_centre : tsc_pkg::MISS_ENTRY;
        ne = (r >= 2) ? prev_row[c] : tsc_pkg::MISS_ENTRY;
        row_end = (c + 1 >= wv);
        res = '0;
        has = (r >= 1);
        if (has)
        begin
            res.nd = ce[tsc_pkg::MISS_IDX];
            if (!res.nd)
                cell_math(we, ce, ee, ne, entry, res.slope, res.curv);
            res.col  = 10'(c);
            res.row  = 10'(r - 1);
            res.last = (r >= hv) && row_end;
        end
        last_centre = ce;
        prev_row[c] = ce;
        cur_row[c]  = entry;
        if (row_end)
        begin
            col_cnt = 0;
            row_cnt = (r >= hv) ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
        return has;
    endfunction

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    task automatic wait_drained();
        while (pending_cells.size() != 0)
            @(posedge clk);
    endtask

    // write one register once the block has gone quiet
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tsc_pkg::CFG_WIDTH:   p_width   = value[10:0];
            tsc_pkg::CFG_HEIGHT:  p_height  = value[10:0];
            tsc_pkg::CFG_SPACING: p_spacing = value;
            default:     ;
        endcase
    endtask

    // one sample transfer; hold valid across back-to-back items
    task automatic send_item(input logic [23:0] hgt, input bit miss, input bit known,
                             input cell_t typed);
        cell_t res;
        bit    has;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hgt;
        s_tuser  <= miss;
        do @(posedge clk); while (!s_tready);
        has = advance_window(hgt, miss, res);
        if (has)
        begin
            if (known)
            begin
                res.slope = typed.slope;
                res.curv  = typed.curv;
                res.nd    = typed.nd;
            end
            pending_cells.insert(pending_cells.size(), res);
        end
    endtask

    function automatic logic [23:0] pick_height(input int mode, input logic [23:0] base);
        case (mode)
            0:       return base + 24'($urandom_range(0, 2000)) - 24'd1000;
            1:       return 24'($urandom);
            default:
                case ($urandom_range(0, 3))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return 24'h000000;
                    default: return 24'hFFFFFF;
                endcase
        endcase
    endfunction

    // configure, then stream a whole frame plus its padding row
    task automatic run_frame(input logic [10:0] w_reg, input logic [10:0] h_reg,
                             input logic [23:0] sp, input int miss_pct, input int mode,
                             input bit counted);
        int          wv, hv;
        logic [23:0] base;
        bit          miss;
        wv = (w_reg == 0) ? 1 : ((w_reg > MAX_W) ? MAX_W : w_reg);
        hv = (h_reg == 0) ? 1 : ((h_reg > MAX_H) ? MAX_H : h_reg);
        // upper data bits carry noise; only the low 11 reach the size registers
        write_reg(tsc_pkg::CFG_WIDTH,   {13'($urandom), w_reg});
        write_reg(tsc_pkg::CFG_HEIGHT,  {13'($urandom), h_reg});
        write_reg(tsc_pkg::CFG_SPACING, sp);
        base = 24'($urandom);
        for (int r = 0; r <= hv; r++)
            for (int c = 0; c < wv; c++)
            begin
                // the padding row is forced missing whatever its flag says
                miss = (r < hv) ? ($urandom_range(0, 99) < miss_pct) : $urandom_range(0, 1);
                send_item(pick_height(mode, base), miss, 1'b0, '0);
                if (counted)
                begin
                    rand_items++;
                    quiet = (rand_items >= RANDOM_ITEMS - QUIET_TAIL);
                end
            end
    endtask

    function automatic void dir_cfg(input logic [1:0] idx, input logic [23:0] value);
        dir_rows.insert(dir_rows.size(), '{ROW_CFG, idx, value, 1'b0, 1'b0, 1'b0, '0});
    endfunction

    function automatic void dir_item(input logic [23:0] hgt, input bit miss,
                                     input bit drain, input bit known, input cell_t typed);
        dir_rows.insert(dir_rows.size(),
                        '{ROW_ITEM, tsc_pkg::CFG_WIDTH, hgt, miss, drain, known, typed});
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall bursts, then in-order field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(1, 19);
        end
    end

    always @(posedge clk)
    begin
        cell_t exp_cell;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cells.size() == 0)
                report("result transfer with nothing expected");
            else
            begin
                exp_cell = pending_cells.pop_front();
                if (m_tdata[15:0] !== exp_cell.slope)
                    report($sformatf("cell %0d,%0d slope %h exp %h", exp_cell.row,
                                     exp_cell.col, m_tdata[15:0], exp_cell.slope));
                if (m_tdata[47:16] !== exp_cell.curv)
                    report($sformatf("cell %0d,%0d curvature %h exp %h", exp_cell.row,
                                     exp_cell.col, m_tdata[47:16], exp_cell.curv));
                if (m_tdata[57:48] !== exp_cell.col)
                    report($sformatf("column %0d exp %0d", m_tdata[57:48], exp_cell.col));
                if (m_tdata[67:58] !== exp_cell.row)
                    report($sformatf("row %0d exp %0d", m_tdata[67:58], exp_cell.row));
                if (m_tuser !== exp_cell.nd)
                    report($sformatf("cell %0d,%0d no_data %b exp %b", exp_cell.row,
                                     exp_cell.col, m_tuser, exp_cell.nd));
                if (m_tlast !== exp_cell.last)
                    report($sformatf("cell %0d,%0d last %b exp %b", exp_cell.row,
                                     exp_cell.col, m_tlast, exp_cell.last));
            end
        end
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck == WATCHDOG)
        begin
            $display("[terrain_slope_curvature_stencil] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cell_t flat, blank;
        int    w_sel, h_sel, sp_sel;
        logic [10:0] w_reg, h_reg;
        logic [23:0] sp;

        for (int i = 0; i < MAX_W; i++)
        begin
            prev_row[i] = '0;
            cur_row[i]  = '0;
        end
        flat  = '0;
        flat.slope = 16'h8000;      // level ground: normal points straight up
        blank = '0;
        blank.nd = 1'b1;

        // 3x3 frame: edge mirroring, both-sides-missing, missing centre,
        // height extremes, and a padding row whose flags mostly say "valid"
        dir_cfg(tsc_pkg::CFG_WIDTH, 24'd3);
        dir_cfg(tsc_pkg::CFG_HEIGHT, 24'd3);
        dir_cfg(tsc_pkg::CFG_SPACING, 24'd256);
        dir_cfg(CFG_UNUSED, 24'h5A5A5A);
        dir_item(24'd100, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd100, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd100, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd100, 1'b0, 1'b0, 1'b1, flat);
        dir_item(24'd0,   1'b1, 1'b0, 1'b1, flat);
        dir_item(24'd100, 1'b0, 1'b0, 1'b1, flat);
        dir_item(24'h7FFFFF, 1'b0, 1'b1, 1'b0, '0);    // hold off until drained
        dir_item(24'h800000, 1'b0, 1'b0, 1'b1, blank);
        dir_item(24'd0, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd0, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd5, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd0, 1'b1, 1'b0, 1'b0, '0);
        // single-cell frame at the largest spacing
        dir_cfg(tsc_pkg::CFG_WIDTH, 24'd1);
        dir_cfg(tsc_pkg::CFG_HEIGHT, 24'd1);
        dir_cfg(tsc_pkg::CFG_SPACING, 24'hFFFFFF);
        dir_item(24'h7FFFFF, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'h800000, 1'b0, 1'b0, 1'b0, '0);
        // two cells at opposite extremes, smallest spacing: steepest slope
        dir_cfg(tsc_pkg::CFG_WIDTH, 24'd2);
        dir_cfg(tsc_pkg::CFG_SPACING, 24'd1);
        dir_item(24'h800000, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'h7FFFFF, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'h001234, 1'b0, 1'b0, 1'b0, '0);
        dir_item(24'd0, 1'b1, 1'b0, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            else
            begin
                if (dir_rows[i].drain)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_item(dir_rows[i].value, dir_rows[i].miss, dir_rows[i].known,
                          dir_rows[i].typed);
            end
        end

        while (rand_items < RANDOM_ITEMS)
        begin
            w_sel  = $urandom_range(0, 9);
            h_sel  = $urandom_range(0, 9);
            sp_sel = $urandom_range(0, 9);
            w_reg  = (w_sel < 4) ? 11'(w_sel) : 11'($urandom_range(1, 24));
            h_reg  = (h_sel < 2) ? 11'(h_sel) : 11'($urandom_range(1, 8));
            case (sp_sel)
                0:       sp = 24'd0;
                1:       sp = 24'd1;
                2:       sp = 24'hFFFFFF;
                3:       sp = 24'($urandom);
                default: sp = 24'($urandom_range(16, 4096));
            endcase
            run_frame(w_reg, h_reg, sp, $urandom_range(0, 30), $urandom_range(0, 2), 1'b1);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("[terrain_slope_curvature_stencil] OK");
        else
            $display("[terrain_slope_curvature_stencil] ERROR");
        $finish;
    end

endmodule
